### src/bwt_pkg.sv
package bwt_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_READ_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_WRITE_LIMIT = 2'd1;
    localparam logic [1:0] CFG_TICKS       = 2'd2;
    localparam logic [1:0] CFG_WINDOW_MS   = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [47:0] RST_READ_LIMIT  = 48'd1048576;
    localparam logic [47:0] RST_WRITE_LIMIT = 48'd1048576;
    localparam logic [19:0] RST_TICKS       = 20'd100;
    localparam logic [15:0] RST_WINDOW_MS   = 16'd1000;

    // Milliseconds in one second; elapsed ticks are scaled by it for the window check.
    localparam logic [31:0] MS_PER_SECOND = 32'd1000;

    // Operand widths of the shared divider.
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_CNT_W = 7;

    // Request to the shared divider: dividend is left aligned, nbits its significant bits.
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
        logic [DIV_CNT_W-1:0] nbits;
    } t_div_req;

    // Answer of the shared divider: done pulses for one cycle with the quotient.
    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

### src/io_bandwidth_throttle.sv
// An accepted item passes the window product, the restart check, three divisions and the
// decision into the output register; the shared bit-serial divider produces
// 64 + 32 + 48 quotient bits, one per cycle, for the three divisions of an item.
// The input is stalled while an item is in work; a pending result waits in the output register.
// Reset is synchronous and active low; it restores the configuration defaults
// and clears all counters and the window.
module io_bandwidth_throttle (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [31:0] i_req_size,
    input  logic [31:0] i_now_ticks,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_status,
    output logic [63:0] o_window_bytes_now,
    output logic [63:0] o_read_bytes_sum,
    output logic [63:0] o_write_bytes_sum,
    output logic [31:0] o_read_throttle_hits,
    output logic [31:0] o_write_throttle_hits
);

    logic [47:0] r_read_limit;
    logic [47:0] r_write_limit;
    logic [19:0] r_ticks;
    logic [15:0] r_window_ms;

    bwt_pkg::t_div_req div_req;
    bwt_pkg::t_div_rsp div_rsp;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_limit  <= bwt_pkg::RST_READ_LIMIT;
            r_write_limit <= bwt_pkg::RST_WRITE_LIMIT;
            r_ticks       <= bwt_pkg::RST_TICKS;
            r_window_ms   <= bwt_pkg::RST_WINDOW_MS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bwt_pkg::CFG_READ_LIMIT:  r_read_limit  <= i_cfg_data;
                bwt_pkg::CFG_WRITE_LIMIT: r_write_limit <= i_cfg_data;
                bwt_pkg::CFG_TICKS:       r_ticks       <= i_cfg_data[19:0];
                bwt_pkg::CFG_WINDOW_MS:   r_window_ms   <= i_cfg_data[15:0];
                default: begin
                    r_ticks <= r_ticks;
                end
            endcase
        end
    end

    // Sequencer with the accounting state and result register.
    bwt_core u_core (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_read_limit          (r_read_limit),
        .i_write_limit         (r_write_limit),
        .i_ticks               (r_ticks),
        .i_window_ms           (r_window_ms),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_req_type            (i_req_type),
        .i_req_size            (i_req_size),
        .i_now_ticks           (i_now_ticks),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_status              (o_status),
        .o_window_bytes_now    (o_window_bytes_now),
        .o_read_bytes_sum      (o_read_bytes_sum),
        .o_write_bytes_sum     (o_write_bytes_sum),
        .o_read_throttle_hits  (o_read_throttle_hits),
        .o_write_throttle_hits (o_write_throttle_hits),
        .o_div_req             (div_req),
        .i_div_rsp             (div_rsp)
    );

    // Shared iterative divider.
    bwt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule

### src/bwt_div.sv
module bwt_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bwt_pkg::t_div_req i_req,
    output bwt_pkg::t_div_rsp o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [bwt_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [bwt_pkg::DIV_NUM_W-1:0] r_num;
    logic [bwt_pkg::DIV_NUM_W-1:0] r_quo;
    logic [bwt_pkg::DIV_DEN_W-1:0] r_rem;
    logic [bwt_pkg::DIV_DEN_W-1:0] r_den;

    logic [bwt_pkg::DIV_DEN_W:0]   shifted;
    logic [bwt_pkg::DIV_DEN_W+1:0] diff;
    logic                          fits;

    // One restoring step: bring down the next dividend bit and try to subtract.
    always_comb begin
        shifted = {r_rem, r_num[bwt_pkg::DIV_NUM_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_den};
        fits    = ~diff[bwt_pkg::DIV_DEN_W+1];
    end

    // Iteration registers, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.nbits;
                r_num  <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem <= fits ? diff[bwt_pkg::DIV_DEN_W-1:0] : shifted[bwt_pkg::DIV_DEN_W-1:0];
                r_quo <= {r_quo[bwt_pkg::DIV_NUM_W-2:0], fits};
                r_num <= {r_num[bwt_pkg::DIV_NUM_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == bwt_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

`ifndef SYNTHESIS
    // The completion flag is a single-cycle pulse.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held for more than one cycle");

    // A new division is never started while one is running.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    // The divisor of a running division is never zero.
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_den != '0))
        else $error("divider running with a zero divisor");
`endif

endmodule

### src/bwt_core.sv
module bwt_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [47:0]       i_read_limit,
    input  logic [47:0]       i_write_limit,
    input  logic [19:0]       i_ticks,
    input  logic [15:0]       i_window_ms,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_req_type,
    input  logic [31:0]       i_req_size,
    input  logic [31:0]       i_now_ticks,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_status,
    output logic [63:0]       o_window_bytes_now,
    output logic [63:0]       o_read_bytes_sum,
    output logic [63:0]       o_write_bytes_sum,
    output logic [31:0]       o_read_throttle_hits,
    output logic [31:0]       o_write_throttle_hits,
    output bwt_pkg::t_div_req o_div_req,
    input  bwt_pkg::t_div_rsp i_div_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_GO,
        S_WAIT,
        S_RESTART,
        S_DECIDE
    } t_state;

    typedef enum logic [1:0] {
        OP_RATE,
        OP_REQ,
        OP_LIMIT
    } t_op;

    t_state r_state, n_state;
    t_op    r_op, n_op;

    // Latched request.
    logic        r_type, n_type;
    logic [31:0] r_size, n_size;
    logic [31:0] r_now, n_now;

    // Intermediate results.
    logic [35:0] r_prod, n_prod;
    logic [31:0] r_elapsed, n_elapsed;
    logic [63:0] r_rate, n_rate;
    logic [31:0] r_req_rate, n_req_rate;
    logic [47:0] r_limit, n_limit;

    // Accounting state.
    logic [31:0] r_window_start, n_window_start;
    logic [63:0] r_window_bytes, n_window_bytes;
    logic [63:0] r_read_total, n_read_total;
    logic [63:0] r_write_total, n_write_total;
    logic [31:0] r_read_hits, n_read_hits;
    logic [31:0] r_write_hits, n_write_hits;

    // Result register.
    logic        r_out_valid, n_out_valid;
    logic        r_status, n_status;
    logic [63:0] r_wb_out, n_wb_out;

    logic [19:0] tps_eff;
    logic [47:0] lim_bps;
    logic [31:0] elapsed0;
    logic [31:0] elapsed1;
    logic [41:0] elapsed_ms;
    logic [64:0] rate_sum;
    logic        throttled;
    logic        in_accept;
    logic        out_free;

    // A zero tick rate counts as one tick per second.
    assign tps_eff   = (i_ticks == '0) ? 20'd1 : i_ticks;
    assign lim_bps   = r_type ? i_write_limit : i_read_limit;
    assign elapsed0  = r_now - r_window_start;
    assign elapsed1  = (elapsed0 == '0) ? 32'd1 : elapsed0;
    // Elapsed ticks times 1000; the constant factor reduces to shifts and adds.
    assign elapsed_ms = {10'b0, elapsed0} * {10'b0, bwt_pkg::MS_PER_SECOND};
    assign rate_sum  = {1'b0, r_rate} + {33'b0, r_req_rate};
    assign throttled = rate_sum[64] || (rate_sum[63:0] > {16'b0, r_limit});
    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;

    // Operands for the shared divider, chosen by the current operation.
    always_comb begin
        o_div_req.start    = (r_state == S_GO);
        o_div_req.dividend = '0;
        o_div_req.divisor  = bwt_pkg::MS_PER_SECOND;
        o_div_req.nbits    = '0;
        case (r_op)
            OP_RATE: begin
                o_div_req.dividend = r_window_bytes;
                o_div_req.divisor  = r_elapsed;
                o_div_req.nbits    = bwt_pkg::DIV_CNT_W'(64);
            end
            OP_REQ: begin
                o_div_req.dividend = {r_size, 32'b0};
                o_div_req.divisor  = r_elapsed;
                o_div_req.nbits    = bwt_pkg::DIV_CNT_W'(32);
            end
            OP_LIMIT: begin
                o_div_req.dividend = {lim_bps, 16'b0};
                o_div_req.divisor  = {12'b0, tps_eff};
                o_div_req.nbits    = bwt_pkg::DIV_CNT_W'(48);
            end
            default: begin
                o_div_req.nbits = '0;
            end
        endcase
    end

    // Sequencer: window product, restart check, then three divisions and the decision.
    always_comb begin
        n_state        = r_state;
        n_op           = r_op;
        n_type         = r_type;
        n_size         = r_size;
        n_now          = r_now;
        n_prod         = r_prod;
        n_elapsed      = r_elapsed;
        n_rate         = r_rate;
        n_req_rate     = r_req_rate;
        n_limit        = r_limit;
        n_window_start = r_window_start;
        n_window_bytes = r_window_bytes;
        n_read_total   = r_read_total;
        n_write_total  = r_write_total;
        n_read_hits    = r_read_hits;
        n_write_hits   = r_write_hits;
        n_status       = r_status;
        n_wb_out       = r_wb_out;
        n_out_valid    = (r_out_valid && !i_out_stall) ? 1'b0 : r_out_valid;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_type  = i_req_type;
                    n_size  = i_req_size;
                    n_now   = i_now_ticks;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = {16'b0, tps_eff} * {20'b0, i_window_ms};
                n_state = S_RESTART;
            end
            S_GO: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_div_rsp.done) begin
                    case (r_op)
                        OP_RATE: begin
                            n_rate  = i_div_rsp.quotient;
                            n_op    = OP_REQ;
                            n_state = S_GO;
                        end
                        OP_REQ: begin
                            n_req_rate = i_div_rsp.quotient[31:0];
                            n_op       = OP_LIMIT;
                            n_state    = S_GO;
                        end
                        default: begin
                            n_limit = i_div_rsp.quotient[47:0];
                            n_state = S_DECIDE;
                        end
                    endcase
                end
            end
            S_RESTART: begin
                // Elapsed exceeds floor(ticks * window_ms / 1000) exactly when
                // 1000 * elapsed is above ticks * window_ms.
                // A restarted window has zero elapsed ticks, which counts as one.
                if ({6'b0, r_prod} < elapsed_ms) begin
                    n_window_bytes = '0;
                    n_window_start = r_now;
                    n_elapsed      = 32'd1;
                end else begin
                    n_elapsed = elapsed1;
                end
                n_op    = OP_RATE;
                n_state = S_GO;
            end
            S_DECIDE: begin
                if (out_free) begin
                    if (throttled) begin
                        if (r_type) begin
                            n_write_hits = r_write_hits + 32'd1;
                        end else begin
                            n_read_hits = r_read_hits + 32'd1;
                        end
                    end else begin
                        if (r_type) begin
                            n_write_total = r_write_total + {32'b0, r_size};
                        end else begin
                            n_read_total = r_read_total + {32'b0, r_size};
                        end
                        n_window_bytes = r_window_bytes + {32'b0, r_size};
                    end
                    n_status    = throttled;
                    n_wb_out    = throttled ? r_window_bytes
                                            : r_window_bytes + {32'b0, r_size};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_op           <= OP_RATE;
            r_out_valid    <= 1'b0;
            r_window_start <= '0;
            r_window_bytes <= '0;
            r_read_total   <= '0;
            r_write_total  <= '0;
            r_read_hits    <= '0;
            r_write_hits   <= '0;
        end else begin
            r_state        <= n_state;
            r_op           <= n_op;
            r_out_valid    <= n_out_valid;
            r_window_start <= n_window_start;
            r_window_bytes <= n_window_bytes;
            r_read_total   <= n_read_total;
            r_write_total  <= n_write_total;
            r_read_hits    <= n_read_hits;
            r_write_hits   <= n_write_hits;
            r_type         <= n_type;
            r_size         <= n_size;
            r_now          <= n_now;
            r_prod         <= n_prod;
            r_elapsed      <= n_elapsed;
            r_rate         <= n_rate;
            r_req_rate     <= n_req_rate;
            r_limit        <= n_limit;
            r_status       <= n_status;
            r_wb_out       <= n_wb_out;
        end
    end

    assign o_in_stall            = (r_state != S_IDLE);
    assign o_out_valid           = r_out_valid;
    assign o_status              = r_status;
    assign o_window_bytes_now    = r_wb_out;
    assign o_read_bytes_sum      = r_read_total;
    assign o_write_bytes_sum     = r_write_total;
    assign o_read_throttle_hits  = r_read_hits;
    assign o_write_throttle_hits = r_write_hits;

`ifndef SYNTHESIS
    // An accepted item keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input not stalled after an item was accepted");

    // Totals and hit counters move only when a decision is written out.
    a_counters_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DECIDE) |=> ($stable(r_read_total) && $stable(r_write_total)
            && $stable(r_read_hits) && $stable(r_write_hits)))
        else $error("counter changed outside the decision step");

    // The divisor used for the rate divisions is never zero.
    a_elapsed_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WAIT) && ((r_op == OP_RATE) || (r_op == OP_REQ)))
            |-> (r_elapsed != '0))
        else $error("elapsed tick count is zero during a rate division");
`endif

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;

    // Request directions and verdicts.
    localparam logic REQ_READ     = 1'b0;
    localparam logic REQ_WRITE    = 1'b1;
    localparam logic ST_ADMITTED  = 1'b0;
    localparam logic ST_THROTTLED = 1'b1;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int ITEMS_PER_PHASE = 325;

    typedef struct packed {
        logic        req_type;
        logic [31:0] req_size;
        logic [31:0] now_ticks;
    } t_req;

    typedef struct packed {
        logic        status;
        logic [63:0] window_bytes;
        logic [63:0] read_sum;
        logic [63:0] write_sum;
        logic [31:0] read_hits;
        logic [31:0] write_hits;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = bwt_pkg::CFG_READ_LIMIT;
    logic [47:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_req_type = REQ_READ;
    logic [31:0] i_req_size = '0;
    logic [31:0] i_now_ticks = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_status;
    logic [63:0] o_window_bytes_now;
    logic [63:0] o_read_bytes_sum;
    logic [63:0] o_write_bytes_sum;
    logic [31:0] o_read_throttle_hits;
    logic [31:0] o_write_throttle_hits;

    io_bandwidth_throttle i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_req_type            (i_req_type),
        .i_req_size            (i_req_size),
        .i_now_ticks           (i_now_ticks),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_status              (o_status),
        .o_window_bytes_now    (o_window_bytes_now),
        .o_read_bytes_sum      (o_read_bytes_sum),
        .o_write_bytes_sum     (o_write_bytes_sum),
        .o_read_throttle_hits  (o_read_throttle_hits),
        .o_write_throttle_hits (o_write_throttle_hits)
    );

    // Requests waiting to be sent and verdicts waiting to come out.
    t_req     req_q[$];
    t_verdict verdict_q[$];

    int send_idle_pct = 24;
    int recv_idle_pct = 64;
    int mismatches = 0;
    int cycle_count = 0;
    logic [31:0] gen_now = '0;

    // Limiter configuration as the block should hold it.
    logic [47:0] cfg_rd_limit = bwt_pkg::RST_READ_LIMIT;
    logic [47:0] cfg_wr_limit = bwt_pkg::RST_WRITE_LIMIT;
    logic [19:0] cfg_tps = bwt_pkg::RST_TICKS;
    logic [15:0] cfg_win_ms = bwt_pkg::RST_WINDOW_MS;

    // Limiter state as the block should hold it.
    logic [31:0] win_start = '0;
    logic [63:0] win_bytes = '0;
    logic [63:0] rd_total = '0;
    logic [63:0] wr_total = '0;
    logic [31:0] rd_hits = '0;
    logic [31:0] wr_hits = '0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Admission decision for one accepted request; queues the verdict it should produce.
    task automatic judge_request(input t_req r);
        logic [63:0] tps_e;
        logic [63:0] span;
        logic [63:0] rate;
        logic [63:0] req_rate;
        logic [63:0] lim;
        logic [64:0] sum;
        logic [31:0] elapsed;
        logic        throttled;
        t_verdict    v;
        tps_e = (cfg_tps == '0) ? 64'd1 : {44'd0, cfg_tps};
        span = tps_e * {48'd0, cfg_win_ms} / {32'd0, bwt_pkg::MS_PER_SECOND};

        // The window restarts first, whatever the verdict turns out to be.
        elapsed = r.now_ticks - win_start;
        if ({32'd0, elapsed} > span) begin
            win_bytes = '0;
            win_start = r.now_ticks;
        end
        elapsed = r.now_ticks - win_start;
        if (elapsed == '0) begin
            elapsed = 32'd1;
        end

        rate = win_bytes / {32'd0, elapsed};
        req_rate = {32'd0, r.req_size} / {32'd0, elapsed};
        sum = {1'b0, rate} + {1'b0, req_rate};
        lim = ((r.req_type == REQ_WRITE) ? {16'd0, cfg_wr_limit} : {16'd0, cfg_rd_limit})
            / tps_e;
        throttled = sum[64] || (sum[63:0] > lim);

        if (throttled) begin
            if (r.req_type == REQ_WRITE) wr_hits = wr_hits + 1;
            else rd_hits = rd_hits + 1;
        end else begin
            if (r.req_type == REQ_WRITE) wr_total = wr_total + {32'd0, r.req_size};
            else rd_total = rd_total + {32'd0, r.req_size};
            win_bytes = win_bytes + {32'd0, r.req_size};
        end

        v.status = throttled ? ST_THROTTLED : ST_ADMITTED;
        v.window_bytes = win_bytes;
        v.read_sum = rd_total;
        v.write_sum = wr_total;
        v.read_hits = rd_hits;
        v.write_hits = wr_hits;
        verdict_q.push_back(v);
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch in %s: expected %h, got %h", field, want, got);
            end
        end
    endtask

    // Request driver: predicts each accepted request and presents the next one.
    always @(posedge i_clk) begin : drive
        t_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                judge_request('{i_req_type, i_req_size, i_now_ticks});
            end
            if (!i_in_valid || !o_in_stall) begin
                if (req_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    nxt = req_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_req_type <= nxt.req_type;
                    i_req_size <= nxt.req_size;
                    i_now_ticks <= nxt.now_ticks;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Verdict monitor: compares each verdict taken at the output with the oldest prediction.
    always @(posedge i_clk) begin : watch
        t_verdict want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected verdict: status %b window %h",
                                 o_status, o_window_bytes_now);
                    end
                end else begin
                    want = verdict_q.pop_front();
                    check_field("status", {63'd0, want.status}, {63'd0, o_status});
                    check_field("window_bytes_now", want.window_bytes, o_window_bytes_now);
                    check_field("read_bytes_sum", want.read_sum, o_read_bytes_sum);
                    check_field("write_bytes_sum", want.write_sum, o_write_bytes_sum);
                    check_field("read_throttle_hits", {32'd0, want.read_hits},
                                {32'd0, o_read_throttle_hits});
                    check_field("write_throttle_hits", {32'd0, want.write_hits},
                                {32'd0, o_write_throttle_hits});
                end
            end
            i_out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Waits until every request went in and every verdict came out.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (req_q.size() != 0 || i_in_valid || verdict_q.size() != 0);
    endtask

    // One register write; called right after a rising edge, returns at the handshake edge.
    task automatic cfg_write(input logic [1:0] idx, input logic [47:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            bwt_pkg::CFG_READ_LIMIT:  cfg_rd_limit = data;
            bwt_pkg::CFG_WRITE_LIMIT: cfg_wr_limit = data;
            bwt_pkg::CFG_TICKS:       cfg_tps = data[19:0];
            bwt_pkg::CFG_WINDOW_MS:   cfg_win_ms = data[15:0];
            default: ;
        endcase
    endtask

    // Limiter settings for each random phase, extremes first.
    task automatic apply_setting(input int phase);
        @(posedge i_clk);
        case (phase)
            1: begin
                // Zero-length window, with a zero read limit and the widest write limit.
                cfg_write(bwt_pkg::CFG_READ_LIMIT, 48'd0);
                cfg_write(bwt_pkg::CFG_WRITE_LIMIT, 48'hFFFF_FFFF_FFFF);
                cfg_write(bwt_pkg::CFG_TICKS, {28'hFFF_FFFF, 20'd1});
                cfg_write(bwt_pkg::CFG_WINDOW_MS, {32'hFFFF_FFFF, 16'd1});
            end
            2: begin
                cfg_write(bwt_pkg::CFG_READ_LIMIT, 48'hFFFF_FFFF_FFFF);
                cfg_write(bwt_pkg::CFG_WRITE_LIMIT, 48'd0);
                cfg_write(bwt_pkg::CFG_TICKS, 48'd1000000);
                cfg_write(bwt_pkg::CFG_WINDOW_MS, 48'd65535);
            end
            3: begin
                cfg_write(bwt_pkg::CFG_READ_LIMIT, 48'd5000000);
                cfg_write(bwt_pkg::CFG_WRITE_LIMIT, 48'd20000000);
                cfg_write(bwt_pkg::CFG_TICKS, 48'd1000);
                cfg_write(bwt_pkg::CFG_WINDOW_MS, 48'd250);
            end
            4: begin
                // A tick rate of zero counts as one.
                cfg_write(bwt_pkg::CFG_READ_LIMIT, 48'd200000);
                cfg_write(bwt_pkg::CFG_WRITE_LIMIT, 48'd100000);
                cfg_write(bwt_pkg::CFG_TICKS, {28'hA5A_5A5A, 20'd0});
                cfg_write(bwt_pkg::CFG_WINDOW_MS, 48'd3000);
            end
            5: begin
                cfg_write(bwt_pkg::CFG_READ_LIMIT, 48'h100_0000_0000);
                cfg_write(bwt_pkg::CFG_WRITE_LIMIT, 48'h10_0000_0000);
                cfg_write(bwt_pkg::CFG_TICKS, 48'hF_FFFF);
                cfg_write(bwt_pkg::CFG_WINDOW_MS, 48'd1);
            end
            default: begin
                cfg_write(bwt_pkg::CFG_READ_LIMIT,
                          48'({$urandom, $urandom} >> $urandom_range(40, 16)));
                cfg_write(bwt_pkg::CFG_WRITE_LIMIT,
                          48'({$urandom, $urandom} >> $urandom_range(40, 16)));
                cfg_write(bwt_pkg::CFG_TICKS, 48'($urandom_range(1000000, 1)));
                cfg_write(bwt_pkg::CFG_WINDOW_MS, 48'($urandom_range(65535, 1)));
            end
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    // Directed requests under the reset configuration: 10485 bytes per tick, 100-tick window.
    task automatic queue_directed();
        // Zero elapsed at time zero, then a request exactly at the limit.
        req_q.push_back('{REQ_READ, 32'd0, 32'd0});
        req_q.push_back('{REQ_READ, 32'd10485, 32'd0});
        req_q.push_back('{REQ_WRITE, 32'd1, 32'd0});
        req_q.push_back('{REQ_WRITE, 32'd0, 32'd0});
        req_q.push_back('{REQ_READ, 32'hFFFF_FFFF, 32'd50});
        // Elapsed equal to the window length keeps the window; one tick more restarts it.
        req_q.push_back('{REQ_WRITE, 32'd1000000, 32'd100});
        req_q.push_back('{REQ_READ, 32'hFFFF_FFFF, 32'd101});
        // Tick counter wraps around.
        req_q.push_back('{REQ_READ, 32'd5000, 32'hFFFF_FFFF});
        req_q.push_back('{REQ_WRITE, 32'h8000_0000, 32'h0000_0010});
        req_q.push_back('{REQ_WRITE, 32'd173247, 32'h0000_0010});
        req_q.push_back('{REQ_READ, 32'd0, 32'h0000_0010});
        req_q.push_back('{REQ_READ, 32'd17, 32'h0000_0010});
        req_q.push_back('{REQ_WRITE, 32'hAAAA_AAAA, 32'h7FFF_FFFF});
        req_q.push_back('{REQ_READ, 32'h5555_5555, 32'h8000_0000});
        req_q.push_back('{REQ_WRITE, 32'd0, 32'h5555_5555});
        req_q.push_back('{REQ_READ, 32'd10485, 32'hAAAA_AAAA});
        req_q.push_back('{REQ_WRITE, 32'd20970, 32'hAAAA_AAAC});
        req_q.push_back('{REQ_READ, 32'd1, 32'hAAAA_AAAC});
        gen_now = 32'hAAAA_AAAC;
    endtask

    // Random requests shaped by the current limits: ticks mostly advance within the window,
    // sizes cluster around the per-tick limit, with jumps and extremes mixed in.
    task automatic queue_random(input int n);
        t_req        it;
        logic [63:0] tps_e;
        logic [63:0] span_e;
        logic [63:0] per_tick;
        logic [63:0] sz;
        int          step_max;
        int          k;
        tps_e = (cfg_tps == '0) ? 64'd1 : {44'd0, cfg_tps};
        span_e = tps_e * {48'd0, cfg_win_ms} / {32'd0, bwt_pkg::MS_PER_SECOND};
        step_max = ((span_e >> 2) > 64) ? 65 : int'(span_e >> 2) + 1;
        for (k = 0; k < n; k++) begin
            it.req_type = $urandom_range(1, 0) ? REQ_WRITE : REQ_READ;
            per_tick = ((it.req_type == REQ_WRITE) ? {16'd0, cfg_wr_limit}
                                                   : {16'd0, cfg_rd_limit}) / tps_e;
            case ($urandom_range(15, 0))
                0: gen_now = $urandom;
                1: gen_now = gen_now + span_e[31:0] + 32'd1 + $urandom_range(3, 0);
                2, 3: ;
                default: gen_now = gen_now + $urandom_range(step_max, 0);
            endcase
            case ($urandom_range(3, 0))
                0: sz = {32'd0, $urandom >> $urandom_range(31, 0)};
                1: begin
                    case ($urandom_range(2, 0))
                        0: sz = 64'd0;
                        1: sz = 64'hFFFF_FFFF;
                        default: sz = {32'd0, $urandom};
                    endcase
                end
                default: begin
                    sz = per_tick * $urandom_range(step_max * 4, 1) / $urandom_range(3, 1);
                    sz = sz + $urandom_range(2, 0) - 64'd1;
                    if (sz > 64'hFFFF_FFFF) sz = {32'd0, $urandom};
                end
            endcase
            it.req_size = sz[31:0];
            it.now_ticks = gen_now;
            req_q.push_back(it);
        end
    endtask

    // Run sequence: reset, directed requests, then random phases under several settings.
    initial begin : run
        int phase;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        queue_directed();
        wait_drained();
        for (phase = 1; phase <= 6; phase++) begin
            if (phase == 3) begin
                send_idle_pct = 64;
                recv_idle_pct = 24;
            end else if (phase == 5) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_setting(phase);
            @(negedge i_clk);
            queue_random(ITEMS_PER_PHASE);
            wait_drained();
        end
        // Anything that still comes out now has no prediction behind it.
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

### files.f
src/bwt_pkg.sv
src/bwt_div.sv
src/bwt_core.sv
src/io_bandwidth_throttle.sv
bench/tb.sv
